[src/kdst_pkg.sv]
// package for the keyed duration stats table
// types, widths and defaults shared by the kdst modules, and the sequencer states
// no dependencies
package kdst_pkg;

  localparam int TableEntriesDef = 64;
  localparam int KeyWidthDef     = 32;

  localparam int FieldW    = 32;
  localparam int SlotW     = 6;
  localparam int InDataW   = 64;
  localparam int OutDataW  = 104;
  localparam int OutUserW  = 3;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StHit,
    StCreate,
    StDrop
  } state_e;

  typedef struct packed {
    logic [FieldW-1:0] worst;
    logic [FieldW-1:0] calls;
    logic [FieldW-1:0] total;
  } stats_t;

  typedef struct packed {
    logic             found;
    logic             created;
    logic             dropped;
    logic [SlotW-1:0] slot;
    stats_t           stats;
  } res_t;

endpackage

[src/kdst_store.sv]
// entry storage of the keyed duration stats table: key memory and stats memory
// one shared write port and one shared read port with registered read data
// depends on kdst_pkg
module kdst_store #(
  parameter int ENTRIES  = kdst_pkg::TableEntriesDef,
  parameter int KEY_BITS = kdst_pkg::KeyWidthDef,
  localparam int IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [IdxW-1:0]      rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [IdxW-1:0]      wr_addr_i,
  input  logic [KEY_BITS-1:0]  wr_key_i,
  input  kdst_pkg::stats_t     wr_stats_i,
  output logic [KEY_BITS-1:0]  rd_key_o,
  output kdst_pkg::stats_t     rd_stats_o
);

  logic [KEY_BITS-1:0] key_mem   [ENTRIES];
  kdst_pkg::stats_t    stats_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i]   <= wr_key_i;
      stats_mem[wr_addr_i] <= wr_stats_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o   <= key_mem[rd_addr_i];
      rd_stats_o <= stats_mem[rd_addr_i];
    end
  end

endmodule

[src/kdst_seq.sv]
// sequencer of the keyed duration stats table: key scan, compare and stats update
// drives the kdst_store ports and hands one result to the output register
// depends on kdst_pkg
module kdst_seq #(
  parameter int ENTRIES  = kdst_pkg::TableEntriesDef,
  parameter int KEY_BITS = kdst_pkg::KeyWidthDef,
  localparam int IdxW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CntW    = $clog2(ENTRIES + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [KEY_BITS-1:0]           in_key_i,
  input  logic [kdst_pkg::FieldW-1:0]   in_dur_i,
  input  logic                          out_free_i,
  output logic                          res_load_o,
  output kdst_pkg::res_t                res_o,
  output logic                          rd_en_o,
  output logic [IdxW-1:0]               rd_addr_o,
  output logic                          wr_en_o,
  output logic [IdxW-1:0]               wr_addr_o,
  output logic [KEY_BITS-1:0]           wr_key_o,
  output kdst_pkg::stats_t              wr_stats_o,
  input  logic [KEY_BITS-1:0]           rd_key_i,
  input  kdst_pkg::stats_t              rd_stats_i
);

  kdst_pkg::state_e               state_q, state_d;
  logic [KEY_BITS-1:0]            key_q, key_d;
  logic [kdst_pkg::FieldW-1:0]    dur_q, dur_d;
  logic [IdxW-1:0]                scan_q, scan_d;
  logic [CntW-1:0]                used_q, used_d;
  logic [CntW-1:0]                scan_next;
  kdst_pkg::stats_t               hit_stats;
  kdst_pkg::stats_t               new_stats;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kdst_pkg::StIdle;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    dur_q  <= dur_d;
    scan_q <= scan_d;
  end

  assign scan_next = CntW'(scan_q) + CntW'(1);

  // hit update: wrap add, increment, running max; a new entry starts from the duration
  always_comb begin
    hit_stats.total = rd_stats_i.total + dur_q;
    hit_stats.calls = rd_stats_i.calls + kdst_pkg::FieldW'(1);
    hit_stats.worst = (dur_q > rd_stats_i.worst) ? dur_q : rd_stats_i.worst;
    new_stats.total = dur_q;
    new_stats.calls = kdst_pkg::FieldW'(1);
    new_stats.worst = dur_q;
  end

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    dur_d      = dur_q;
    scan_d     = scan_q;
    used_d     = used_q;
    in_ready_o = 1'b0;
    rd_en_o    = 1'b0;
    rd_addr_o  = scan_q;
    wr_en_o    = 1'b0;
    wr_addr_o  = scan_q;
    wr_key_o   = key_q;
    wr_stats_o = hit_stats;
    res_load_o = 1'b0;
    res_o      = '0;
    case (state_q)
      kdst_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          key_d = in_key_i;
          dur_d = in_dur_i;
          if (used_q == '0) begin
            state_d = kdst_pkg::StCreate;
          end else begin
            rd_en_o   = 1'b1;
            rd_addr_o = '0;
            scan_d    = '0;
            state_d   = kdst_pkg::StScan;
          end
        end
      end
      kdst_pkg::StScan: begin
        if (rd_key_i == key_q) begin
          state_d = kdst_pkg::StHit;
        end else if (scan_next < used_q) begin
          rd_en_o   = 1'b1;
          rd_addr_o = scan_next[IdxW-1:0];
          scan_d    = scan_next[IdxW-1:0];
        end else if (used_q < CntW'(ENTRIES)) begin
          state_d = kdst_pkg::StCreate;
        end else begin
          state_d = kdst_pkg::StDrop;
        end
      end
      kdst_pkg::StHit: begin
        if (out_free_i) begin
          wr_en_o       = 1'b1;
          wr_addr_o     = scan_q;
          wr_stats_o    = hit_stats;
          res_load_o    = 1'b1;
          res_o.found   = 1'b1;
          res_o.slot    = kdst_pkg::SlotW'(scan_q);
          res_o.stats   = hit_stats;
          state_d       = kdst_pkg::StIdle;
        end
      end
      kdst_pkg::StCreate: begin
        if (out_free_i) begin
          wr_en_o       = 1'b1;
          wr_addr_o     = used_q[IdxW-1:0];
          wr_stats_o    = new_stats;
          used_d        = used_q + CntW'(1);
          res_load_o    = 1'b1;
          res_o.created = 1'b1;
          res_o.slot    = kdst_pkg::SlotW'(used_q);
          res_o.stats   = new_stats;
          state_d       = kdst_pkg::StIdle;
        end
      end
      kdst_pkg::StDrop: begin
        if (out_free_i) begin
          res_load_o    = 1'b1;
          res_o.dropped = 1'b1;
          state_d       = kdst_pkg::StIdle;
        end
      end
      default: begin
        state_d = kdst_pkg::StIdle;
      end
    endcase
  end

endmodule

[src/keyed_duration_stats_table.sv]
// Keyed duration stats table: per-section total, call count and worst case of
// measured durations, looked up by key in insertion order. Each input beat is
// scanned against the filled entries before the next beat can be accepted, so
// the time per beat grows with the filled entries on a miss and with the slot
// index on a hit; the key scan reads one entry per cycle through the single
// read port of the entry memory. Input is accepted while a finished result
// still waits in the output register. Reset empties the table at once; no
// clearing pass runs.
// depends on kdst_pkg, kdst_store and kdst_seq
module keyed_duration_stats_table #(
  parameter int TABLE_ENTRIES = kdst_pkg::TableEntriesDef,
  parameter int KEY_WIDTH     = kdst_pkg::KeyWidthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // section_key [31:0], duration_ticks [63:32]
  input  logic [kdst_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // slot_index [5:0], total_after [37:6], calls_after [69:38],
  // worst_after [101:70], zero [103:102]
  output logic [kdst_pkg::OutDataW-1:0]   m_axis_tdata_o,
  // found [0], created [1], dropped [2]
  output logic [kdst_pkg::OutUserW-1:0]   m_axis_tuser_o
);

  localparam int KeyBits = (KEY_WIDTH < kdst_pkg::FieldW) ? KEY_WIDTH : kdst_pkg::FieldW;
  localparam int IdxW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic                 m_valid_q;
  kdst_pkg::res_t       res_q;
  kdst_pkg::res_t       res;
  logic                 res_load;
  logic                 out_free;
  logic                 rd_en;
  logic [IdxW-1:0]      rd_addr;
  logic                 wr_en;
  logic [IdxW-1:0]      wr_addr;
  logic [KeyBits-1:0]   wr_key;
  kdst_pkg::stats_t     wr_stats;
  logic [KeyBits-1:0]   rd_key;
  kdst_pkg::stats_t     rd_stats;

  assign out_free = !m_valid_q || m_axis_tready_i;

  kdst_seq #(
    .ENTRIES  (TABLE_ENTRIES),
    .KEY_BITS (KeyBits)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_key_i   (s_axis_tdata_i[KeyBits-1:0]),
    .in_dur_i   (s_axis_tdata_i[63:32]),
    .out_free_i (out_free),
    .res_load_o (res_load),
    .res_o      (res),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_key_o   (wr_key),
    .wr_stats_o (wr_stats),
    .rd_key_i   (rd_key),
    .rd_stats_i (rd_stats)
  );

  kdst_store #(
    .ENTRIES  (TABLE_ENTRIES),
    .KEY_BITS (KeyBits)
  ) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_addr),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_key_i   (wr_key),
    .wr_stats_i (wr_stats),
    .rd_key_o   (rd_key),
    .rd_stats_o (rd_stats)
  );

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {2'b00, res_q.stats.worst, res_q.stats.calls,
                            res_q.stats.total, res_q.slot};
  assign m_axis_tuser_o  = {res_q.dropped, res_q.created, res_q.found};

endmodule

[dv/testbench.sv]
// testbench for keyed_duration_stats_table: drives section/duration beats,
// predicts hit, new-entry and drop results and checks every output beat
// depends on kdst_pkg and keyed_duration_stats_table
`timescale 1ns / 1ps

module testbench;

  localparam int Slots     = kdst_pkg::TableEntriesDef;
  localparam int CycleCap  = 800_000;
  localparam int RandItems = 1600;
  localparam int HoldLen   = 1500;
  localparam int DrainWait = 120;
  localparam int NumRows   = 16;

  typedef struct packed {
    logic                       found;
    logic                       created;
    logic                       dropped;
    logic [kdst_pkg::SlotW-1:0] slot;
    logic [31:0]                total;
    logic [31:0]                calls;
    logic [31:0]                worst;
  } sample_res_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] dur;
    logic        fill;
    logic        typed;
    sample_res_t res;
  } dir_row_t;

  localparam sample_res_t Open = '0;

  // fill: top the table up with fresh keys before the row
  localparam dir_row_t DirRows [NumRows] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b0, 6'd0, 32'h0000_0000, 32'd1, 32'h0000_0000}},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b0, 6'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF}},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 6'd1, 32'h0000_0000, 32'd2, 32'hFFFF_FFFF}},
    '{32'h0000_0000, 32'h0000_0005, 1'b0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 6'd0, 32'h0000_0005, 32'd2, 32'h0000_0005}},
    '{32'h0000_0000, 32'h0000_0003, 1'b0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 6'd0, 32'h0000_0008, 32'd3, 32'h0000_0005}},
    '{32'h0000_0000, 32'h0000_0008, 1'b0, 1'b0, Open},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b0, 6'd2, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF}},
    '{32'h0000_0001, 32'h8000_0000, 1'b0, 1'b1,
      '{1'b0, 1'b1, 1'b0, 6'd3, 32'h8000_0000, 32'd1, 32'h8000_0000}},
    '{32'h8000_0000, 32'h8000_0001, 1'b0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 6'd2, 32'h0000_0000, 32'd2, 32'h8000_0001}},
    '{32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 1'b0, Open},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{1'b1, 1'b0, 1'b0, 6'd3, 32'h7FFF_FFFF, 32'd2, 32'hFFFF_FFFF}},
    '{32'h1234_5678, 32'h0000_0064, 1'b1, 1'b1,
      '{1'b0, 1'b0, 1'b1, 6'd0, 32'h0, 32'h0, 32'h0}},
    '{32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b0, 1'b1,
      '{1'b0, 1'b0, 1'b1, 6'd0, 32'h0, 32'h0, 32'h0}},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, Open},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, Open},
    '{32'hA5A5_A5A5, 32'h0000_0000, 1'b0, 1'b0, Open}
  };

  logic                          clk_i    = 1'b0;
  logic                          rst_ni   = 1'b0;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [kdst_pkg::InDataW-1:0]  s_tdata  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [kdst_pkg::OutDataW-1:0] m_tdata;
  logic [kdst_pkg::OutUserW-1:0] m_tuser;

  // shadow copy of the statistics table
  logic [31:0] tally_keys   [Slots];
  logic [31:0] tally_totals [Slots];
  logic [31:0] tally_calls  [Slots];
  logic [31:0] tally_worst  [Slots];
  int          tally_used = 0;

  sample_res_t pending_q [$];
  int          fails = 0;
  int          cycle_count = 0;
  int          n_hits = 0;
  int          n_new = 0;
  int          n_drop = 0;
  int          n_checked = 0;
  bit          steady = 1'b0;
  bit          hold_out = 1'b0;

  keyed_duration_stats_table uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleCap) begin
      $display("** keyed_duration_stats_table: FAILED **");
      $finish;
    end
  end

  function automatic sample_res_t tally_sample(logic [31:0] key, logic [31:0] dur);
    sample_res_t r;
    int          hit;
    r   = '0;
    hit = -1;
    for (int i = 0; i < tally_used; i++) begin
      if (hit < 0 && tally_keys[i] == key) hit = i;
    end
    if (hit >= 0) begin
      tally_totals[hit] = tally_totals[hit] + dur;
      tally_calls[hit]  = tally_calls[hit] + 32'd1;
      if (dur > tally_worst[hit]) tally_worst[hit] = dur;
      r.found = 1'b1;
      r.slot  = hit[kdst_pkg::SlotW-1:0];
      r.total = tally_totals[hit];
      r.calls = tally_calls[hit];
      r.worst = tally_worst[hit];
    end else if (tally_used < Slots) begin
      tally_keys[tally_used]   = key;
      tally_totals[tally_used] = dur;
      tally_calls[tally_used]  = 32'd1;
      tally_worst[tally_used]  = dur;
      r.created = 1'b1;
      r.slot    = tally_used[kdst_pkg::SlotW-1:0];
      r.total   = dur;
      r.calls   = 32'd1;
      r.worst   = dur;
      tally_used++;
    end else begin
      r.dropped = 1'b1;
    end
    return r;
  endfunction

  function automatic bit key_taken(logic [31:0] key);
    bit taken;
    taken = 1'b0;
    for (int i = 0; i < tally_used; i++) if (tally_keys[i] == key) taken = 1'b1;
    for (int i = 0; i < NumRows; i++) if (DirRows[i].key == key) taken = 1'b1;
    return taken;
  endfunction

  function automatic logic [31:0] pick_duration();
    logic [31:0] d;
    case ($urandom_range(0, 3))
      0:       d = $urandom_range(0, 255);
      1:       d = 32'hFFFF_FFFF - $urandom_range(0, 255);
      2:       d = $urandom;
      default: d = 32'd1 << $urandom_range(0, 31);
    endcase
    return d;
  endfunction

  task automatic send_sample(logic [31:0] key, logic [31:0] dur, bit typed,
                             sample_res_t typed_res);
    int          gap;
    sample_res_t r;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {dur, key};
    do @(posedge clk_i); while (!s_tready);
    r = tally_sample(key, dur);
    if (r.found) n_hits++;
    else if (r.created) n_new++;
    else n_drop++;
    pending_q.push_back(typed ? typed_res : r);
  endtask

  task automatic fill_table();
    logic [31:0] key;
    while (tally_used < Slots) begin
      key = $urandom;
      if (!key_taken(key)) send_sample(key, pick_duration(), 1'b0, Open);
    end
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endtask

  task automatic check_beat();
    sample_res_t want;
    if (pending_q.size() == 0) begin
      $error("result beat with no sample pending");
      fails++;
    end else begin
      want = pending_q.pop_front();
      n_checked++;
      check_field("found", 32'(want.found), 32'(m_tuser[0]));
      check_field("created", 32'(want.created), 32'(m_tuser[1]));
      check_field("dropped", 32'(want.dropped), 32'(m_tuser[2]));
      check_field("slot_index", 32'(want.slot), 32'(m_tdata[5:0]));
      check_field("total_after", want.total, m_tdata[37:6]);
      check_field("calls_after", want.calls, m_tdata[69:38]);
      check_field("worst_after", want.worst, m_tdata[101:70]);
    end
  endtask

  // result side: random stalls, none in steady phases, one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (hold_out) begin
        hold_out = 1'b0;
        stall = HoldLen;
      end else if (steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 11);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      check_beat();
    end
  end

  initial begin
    logic [31:0] key;
    logic [31:0] slot;
    int          pick;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      if (DirRows[r].fill) fill_table();
      send_sample(DirRows[r].key, DirRows[r].dur, DirRows[r].typed, DirRows[r].res);
    end

    // mostly hits on live keys, mixed with misses on a full table from random and near-miss keys
    for (int n = 0; n < RandItems; n++) begin
      steady = ((n / 150) % 4) == 2;
      if (n == 400) hold_out = 1'b1;
      pick = $urandom_range(0, 99);
      slot = $urandom_range(0, tally_used - 1);
      if (pick < 70) key = tally_keys[slot];
      else if (pick < 90) key = $urandom;
      else key = tally_keys[slot] ^ (32'd1 << $urandom_range(0, 31));
      send_sample(key, pick_duration(), 1'b0, Open);
    end
    steady = 1'b0;
    s_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d samples: %0d hits, %0d new entries, %0d dropped",
             n_hits + n_new + n_drop, n_hits, n_new, n_drop);
    $display("%0d result beats checked, %0d mismatches", n_checked, fails);
    if (fails == 0) begin
      $display("** keyed_duration_stats_table: PASSED **");
    end else begin
      $display("** keyed_duration_stats_table: FAILED **");
    end
    $finish;
  end

endmodule
